### sv/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types, codes and strobe decode for the character lcd write controller
// ----------------------------------------------------------------------------
package clcd_pkg;

    // request modes
    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_CMD    = 3'd1;
    localparam logic [2:0] MODE_CHAR   = 3'd2;
    localparam logic [2:0] MODE_POS    = 3'd3;
    localparam logic [2:0] MODE_CURSOR = 3'd4;
    localparam logic [2:0] MODE_RAW    = 3'd5;
    localparam logic [2:0] MODE_GLYPH  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_HIDE_CMD   = 3'd0;
    localparam logic [2:0] CFG_SHOW_CMD   = 3'd1;
    localparam logic [2:0] CFG_GLYPH_BASE = 3'd2;
    localparam logic [2:0] CFG_HOLD_TICKS = 3'd3;

    localparam logic [7:0] HIDE_CMD_RESET   = 8'h0C;
    localparam logic [7:0] SHOW_CMD_RESET   = 8'h0E;
    localparam logic [7:0] GLYPH_BASE_RESET = 8'h40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
        logic [4:0] position;
        logic       move_first;
        logic       cursor_visible;
    } t_item;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last_strobe;
    } t_strobe;

    typedef struct packed {
        logic [7:0] hide_cmd;
        logic [7:0] show_cmd;
        logic [7:0] glyph_base;
    } t_cfg;

    // one classified request: init sequence or up to three bytes
    typedef struct packed {
        logic            init;
        logic [1:0]      nbytes;
        logic [2:0]      rs;
        logic [2:0][7:0] bytes;
    } t_job;

    function automatic logic [7:0] remap_char(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'hE7:   r = 8'h01;
            8'hE3:   r = 8'h02;
            8'hE1:   r = 8'h03;
            8'hE9:   r = 8'h04;
            8'hC7:   r = 8'h05;
            8'hC3:   r = 8'h06;
            8'hD3:   r = 8'h07;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] last_index(input t_job j);
        logic [3:0] r;
        if (j.init) begin
            r = 4'd15;
        end else begin
            r = {1'b0, j.nbytes, 1'b0} - 4'd1;
        end
        return r;
    endfunction

    // strobe number idx of a job; the init job carries the cursor-off command in byte 0
    function automatic t_strobe strobe_of(input t_job j, input logic [3:0] idx);
        t_strobe    s;
        logic [3:0] t;
        logic [7:0] b;
        logic       rs;
        t  = idx - 4'd4;
        b  = 8'h00;
        rs = 1'b0;
        if (j.init) begin
            case (t[3:1])
                3'd0:    b = 8'h28;
                3'd1:    b = 8'h41;
                3'd2:    b = j.bytes[0];
                3'd3:    b = 8'h80;
                3'd4:    b = 8'h01;
                default: b = 8'h02;
            endcase
            rs = (t[3:1] == 3'd1);
        end else begin
            case (idx[2:1])
                2'd0:    begin b = j.bytes[0]; rs = j.rs[0]; end
                2'd1:    begin b = j.bytes[1]; rs = j.rs[1]; end
                default: begin b = j.bytes[2]; rs = j.rs[2]; end
            endcase
        end
        s.register_select = rs;
        s.nibble          = idx[0] ? b[3:0] : b[7:4];
        if (j.init && idx < 4'd4) begin
            s.register_select = 1'b0;
            s.nibble          = (idx == 4'd3) ? 4'h2 : 4'h3;
        end
        s.last_strobe = (idx == last_index(j));
        return s;
    endfunction

endpackage

### sv/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// accepts requests, tracks the failed flag and turns requests into byte jobs
// ----------------------------------------------------------------------------
module clcd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  clcd_pkg::t_item i_item,
    input  clcd_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output clcd_pkg::t_job  o_job
);

    logic           r_failed;
    logic           n_failed;
    logic           accept;
    logic           emits;
    logic [7:0]     pos_byte;
    logic [7:0]     chr;
    clcd_pkg::t_job job;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    assign pos_byte = i_item.position[4] ? {4'hC, i_item.position[3:0]}
                                         : {4'h8, i_item.position[3:0]};
    assign chr      = clcd_pkg::remap_char(i_item.byte_value);

    always_comb begin
        job        = '0;
        emits      = !r_failed;
        job.nbytes = 2'd1;
        case (i_item.mode)
            clcd_pkg::MODE_INIT: begin
                emits        = 1'b1;
                job.init     = 1'b1;
                job.bytes[0] = i_cfg.hide_cmd;
            end
            clcd_pkg::MODE_CMD: begin
                job.bytes[0] = i_item.byte_value;
            end
            clcd_pkg::MODE_CHAR: begin
                if (i_item.move_first) begin
                    job.nbytes   = 2'd3;
                    job.bytes[0] = i_cfg.hide_cmd;
                    job.bytes[1] = pos_byte;
                    job.bytes[2] = chr;
                    job.rs       = 3'b100;
                end else begin
                    job.bytes[0] = chr;
                    job.rs       = 3'b001;
                end
            end
            clcd_pkg::MODE_POS: begin
                job.nbytes   = 2'd2;
                job.bytes[0] = i_cfg.hide_cmd;
                job.bytes[1] = pos_byte;
            end
            clcd_pkg::MODE_CURSOR: begin
                job.bytes[0] = i_item.cursor_visible ? i_cfg.show_cmd : i_cfg.hide_cmd;
            end
            clcd_pkg::MODE_RAW: begin
                job.bytes[0] = i_item.byte_value;
                job.rs       = 3'b001;
            end
            clcd_pkg::MODE_GLYPH: begin
                job.bytes[0] = i_cfg.glyph_base | 8'h08;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    assign o_push = accept && emits;
    assign o_job  = job;

    always_comb begin
        n_failed = r_failed;
        if (accept && i_item.mode == clcd_pkg::MODE_INIT) begin
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b1;
        end else begin
            r_failed <= n_failed;
        end
    end

endmodule

### sv/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue
// short job fifo between the front and the strobe sequencer
// ----------------------------------------------------------------------------
module clcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output clcd_pkg::t_job o_job
);

    clcd_pkg::t_job                r_mem [clcd_pkg::QUEUE_DEPTH];
    logic [clcd_pkg::QUEUE_AW-1:0] r_wr;
    logic [clcd_pkg::QUEUE_AW-1:0] r_rd;
    logic [clcd_pkg::QUEUE_AW:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == (clcd_pkg::QUEUE_AW+1)'(clcd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// strobe sequencer: walks a job one nibble per transfer into the output register
// ----------------------------------------------------------------------------
module clcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  clcd_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output clcd_pkg::t_strobe o_strobe
);

    logic              r_busy;
    clcd_pkg::t_job    r_job;
    logic [3:0]        r_idx;
    logic              r_ovalid;
    clcd_pkg::t_strobe r_out;
    logic              advance;
    clcd_pkg::t_strobe cur;

    assign advance = !r_ovalid || !i_stall;
    assign o_pop   = !r_busy && !i_q_empty;
    assign cur     = clcd_pkg::strobe_of(r_job, r_idx);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (advance && r_busy) begin
            r_out <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance && r_busy) begin
                r_idx <= r_idx + 4'd1;
                if (cur.last_strobe) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_ovalid <= r_busy;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_strobe = r_out;

endmodule

### sv/char_lcd_nibble_write_controller.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_controller
// two-line character lcd driver on a 4-bit bus, one transfer per enable strobe
// ----------------------------------------------------------------------------
// requests come in on i_valid / o_stall with i_item; each accepted request
// yields its strobes on o_valid / i_stall with o_strobe (register select,
// d7..d4 nibble, last-strobe flag on the final one of the request)
// a byte is two strobes, high nibble first; init gives 16 strobes
// front: classifies the request into a job of up to three bytes and keeps
// the display-failed flag; requests that emit nothing leave no job
// queue: four jobs deep, so requests are taken while strobes still drain
// back: pops each job into its job register and sends one strobe per cycle
// into a registered output unless the receiver stalls, pausing to load each
// job; a request passes the queue, job register and output register before
// its first strobe; receiver stall holds the output register and the
// sequencer; once the queue fills, o_stall goes high
// reset: display marked failed (only init emits), queue empty, config
// registers back to their defaults; config port is always ready
// o_hold_ticks hands the enable hold setting to the pad logic behind it
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  clcd_pkg::t_item   i_item,
    // strobe channel
    output logic              o_valid,
    input  logic              i_stall,
    output clcd_pkg::t_strobe o_strobe,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    // enable hold setting for the pad logic
    output logic [15:0]       o_hold_ticks
);

    clcd_pkg::t_cfg r_cfg;
    logic [15:0]    r_hold_ticks;
    logic           cfg_wr;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    clcd_pkg::t_job front_job;
    clcd_pkg::t_job head_job;

    // config writes go straight into the registers, so the port never pushes back
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr       = i_cfg_valid && o_cfg_ready;
    assign o_hold_ticks = r_hold_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hide_cmd   <= clcd_pkg::HIDE_CMD_RESET;
            r_cfg.show_cmd   <= clcd_pkg::SHOW_CMD_RESET;
            r_cfg.glyph_base <= clcd_pkg::GLYPH_BASE_RESET;
            r_hold_ticks     <= 16'd50;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                clcd_pkg::CFG_HIDE_CMD:   r_cfg.hide_cmd   <= i_cfg_data[7:0];
                clcd_pkg::CFG_SHOW_CMD:   r_cfg.show_cmd   <= i_cfg_data[7:0];
                clcd_pkg::CFG_GLYPH_BASE: r_cfg.glyph_base <= i_cfg_data[7:0];
                clcd_pkg::CFG_HOLD_TICKS: r_hold_ticks     <= i_cfg_data;
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // request side: classify and queue
    clcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    clcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // strobe side: one nibble per transfer
    clcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_strobe  (o_strobe)
    );

endmodule

### sim/clcd_strobe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_strobe_checker
// watches the request, strobe and config channels of the lcd write controller
// ----------------------------------------------------------------------------
// keeps its own copy of the config registers and the display-failed flag,
// turns each accepted request into the strobes it should cause and compares
// every accepted strobe, field by field, with the oldest one still owed
// ----------------------------------------------------------------------------
module clcd_strobe_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  clcd_pkg::t_item     i_req_item,
    input  logic                i_strobe_valid,
    input  logic                i_strobe_stall,
    input  clcd_pkg::t_strobe   i_strobe,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic [15:0]         i_hold_ticks,
    output int                  o_fail_count,
    output int                  o_pending_strobes,
    output int                  o_checked_strobes
);

    localparam logic        RS_COMMAND       = 1'b0;
    localparam logic        RS_DATA          = 1'b1;
    localparam logic [15:0] HOLD_TICKS_RESET = 16'd50;

    logic [7:0]        hide_cmd;
    logic [7:0]        show_cmd;
    logic [7:0]        glyph_base_cmd;
    logic [15:0]       hold_ticks;
    logic              panel_failed;
    clcd_pkg::t_strobe owed_strobes[$];
    int                fail_count    = 0;
    int                checked_count = 0;

    // counts a failure; every one gets reported
    function automatic bit note_failure();
        fail_count++;
        return 1'b1;
    endfunction

    // accented latin-1 letters live in the user glyph slots 1..7
    function automatic logic [7:0] lcd_char_code(input logic [7:0] c);
        logic [7:0] code;
        case (c)
            8'hE7:   code = 8'h01;
            8'hE3:   code = 8'h02;
            8'hE1:   code = 8'h03;
            8'hE9:   code = 8'h04;
            8'hC7:   code = 8'h05;
            8'hC3:   code = 8'h06;
            8'hD3:   code = 8'h07;
            default: code = c;
        endcase
        return code;
    endfunction

    function void queue_strobe(input logic rs, input logic [3:0] nib);
        clcd_pkg::t_strobe s;
        s.register_select = rs;
        s.nibble          = nib;
        s.last_strobe     = 1'b0;
        owed_strobes.push_back(s);
    endfunction

    function void queue_byte(input logic rs, input logic [7:0] b);
        queue_strobe(rs, b[7:4]);
        queue_strobe(rs, b[3:0]);
    endfunction

    // hide cursor, then ddram address: line one at 0x80, line two at 0xc0
    function void queue_cursor_move(input logic [4:0] pos);
        queue_byte(RS_COMMAND, hide_cmd);
        if (pos[4]) begin
            queue_byte(RS_COMMAND, 8'hC0 | {4'h0, pos[3:0]});
        end else begin
            queue_byte(RS_COMMAND, 8'h80 | {4'h0, pos[3:0]});
        end
    endfunction

    function void predict_request(input clcd_pkg::t_item req);
        int first;
        first = owed_strobes.size();
        if (req.mode == clcd_pkg::MODE_INIT) begin
            panel_failed = 1'b0;
            queue_strobe(RS_COMMAND, 4'h3);
            queue_strobe(RS_COMMAND, 4'h3);
            queue_strobe(RS_COMMAND, 4'h3);
            queue_strobe(RS_COMMAND, 4'h2);
            queue_byte(RS_COMMAND, 8'h28);
            queue_byte(RS_DATA, 8'h41);
            queue_cursor_move(5'd0);
            queue_byte(RS_COMMAND, 8'h01);
            queue_byte(RS_COMMAND, 8'h02);
        end else if (!panel_failed) begin
            case (req.mode)
                clcd_pkg::MODE_CMD: begin
                    queue_byte(RS_COMMAND, req.byte_value);
                end
                clcd_pkg::MODE_CHAR: begin
                    if (req.move_first) begin
                        queue_cursor_move(req.position);
                    end
                    queue_byte(RS_DATA, lcd_char_code(req.byte_value));
                end
                clcd_pkg::MODE_POS: begin
                    queue_cursor_move(req.position);
                end
                clcd_pkg::MODE_CURSOR: begin
                    queue_byte(RS_COMMAND, req.cursor_visible ? show_cmd : hide_cmd);
                end
                clcd_pkg::MODE_RAW: begin
                    queue_byte(RS_DATA, req.byte_value);
                end
                clcd_pkg::MODE_GLYPH: begin
                    queue_byte(RS_COMMAND, glyph_base_cmd | 8'h08);
                end
                default: begin
                end
            endcase
        end
        if (owed_strobes.size() > first) begin
            owed_strobes[owed_strobes.size() - 1].last_strobe = 1'b1;
        end
    endfunction

    function void apply_config(input logic [2:0] index, input logic [15:0] data);
        case (index)
            clcd_pkg::CFG_HIDE_CMD:   hide_cmd       = data[7:0];
            clcd_pkg::CFG_SHOW_CMD:   show_cmd       = data[7:0];
            clcd_pkg::CFG_GLYPH_BASE: glyph_base_cmd = data[7:0];
            clcd_pkg::CFG_HOLD_TICKS: hold_ticks     = data;
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        clcd_pkg::t_strobe want;
        if (!i_rst_n) begin
            hide_cmd       = clcd_pkg::HIDE_CMD_RESET;
            show_cmd       = clcd_pkg::SHOW_CMD_RESET;
            glyph_base_cmd = clcd_pkg::GLYPH_BASE_RESET;
            hold_ticks     = HOLD_TICKS_RESET;
            panel_failed   = 1'b1;
            owed_strobes.delete();
        end else begin
            if ($isunknown(i_strobe_valid) && note_failure()) begin
                $error("o_valid unknown out of reset");
            end
            if (i_hold_ticks !== hold_ticks && note_failure()) begin
                $error("hold_ticks expected %0d, actual %0d", hold_ticks, i_hold_ticks);
            end
            // check first so a strobe cannot match a request taken this edge
            if (i_strobe_valid === 1'b1 && !i_strobe_stall) begin
                checked_count++;
                if (owed_strobes.size() == 0) begin
                    if (note_failure()) begin
                        $error("strobe with none owed: register_select %0b nibble %h last %0b",
                               i_strobe.register_select, i_strobe.nibble,
                               i_strobe.last_strobe);
                    end
                end else begin
                    want = owed_strobes.pop_front();
                    if (i_strobe.register_select !== want.register_select && note_failure()) begin
                        $error("register_select expected %0b, actual %0b",
                               want.register_select, i_strobe.register_select);
                    end
                    if (i_strobe.nibble !== want.nibble && note_failure()) begin
                        $error("nibble expected %h, actual %h", want.nibble, i_strobe.nibble);
                    end
                    if (i_strobe.last_strobe !== want.last_strobe && note_failure()) begin
                        $error("last_strobe expected %0b, actual %0b",
                               want.last_strobe, i_strobe.last_strobe);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req_item);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_config(i_cfg_index, i_cfg_data);
            end
        end
        o_fail_count      <= fail_count;
        o_pending_strobes <= owed_strobes.size();
        o_checked_strobes <= checked_count;
    end

endmodule

### sim/char_lcd_nibble_write_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_controller_tb
// request stimulus, strobe back-pressure and verdict for the lcd controller
// ----------------------------------------------------------------------------
// a directed set covers the failed display before init, the init sequence,
// byte extremes, every mode, the accented letters and the unused mode code;
// random phases follow under different register settings and idle patterns,
// one of them with a long strobe hold-off that fills the job queue
// the checker beside the block predicts and compares every strobe
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_controller_tb;

    localparam logic [2:0]  MODE_UNUSED      = 3'd7;
    localparam logic [15:0] HOLD_TICKS_RESET = 16'd50;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam logic [7:0]  ACCENTED_CODES [7] = '{8'hE7, 8'hE3, 8'hE1, 8'hE9,
                                                   8'hC7, 8'hC3, 8'hD3};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    clcd_pkg::t_item   req_item     = '0;
    logic              strobe_valid;
    logic              strobe_stall = 1'b0;
    clcd_pkg::t_strobe strobe_out;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index    = '0;
    logic [15:0]       cfg_data     = '0;
    logic [15:0]       hold_ticks_out;

    int fail_count;
    int pending_strobes;
    int checked_strobes;

    // idle knobs, percent of cycles
    int send_gap_pct   = 0;
    int stall_pct      = 0;
    logic hold_armed   = 1'b0;
    int hold_cycles    = 0;
    int requests_sent  = 0;
    int settings_count = 1;
    int cycle_count    = 0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    char_lcd_nibble_write_controller DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_item       (req_item),
        .o_valid      (strobe_valid),
        .i_stall      (strobe_stall),
        .o_strobe     (strobe_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_hold_ticks (hold_ticks_out)
    );

    clcd_strobe_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_stall       (req_stall),
        .i_req_item        (req_item),
        .i_strobe_valid    (strobe_valid),
        .i_strobe_stall    (strobe_stall),
        .i_strobe          (strobe_out),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_hold_ticks      (hold_ticks_out),
        .o_fail_count      (fail_count),
        .o_pending_strobes (pending_strobes),
        .o_checked_strobes (checked_strobes)
    );

    // strobe receiver: random stall, or one long hold-off once armed so the
    // job queue fills and the request side has to stall
    always @(negedge clk) begin
        if (hold_armed && hold_cycles < LONG_HOLD_CYCLES) begin
            strobe_stall <= 1'b1;
            hold_cycles  <= hold_cycles + 1;
        end else begin
            strobe_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic clcd_pkg::t_item make_request(input logic [2:0] mode,
                                                     input logic [7:0] value,
                                                     input logic [4:0] pos,
                                                     input logic move,
                                                     input logic vis);
        clcd_pkg::t_item req;
        req.mode           = mode;
        req.byte_value     = value;
        req.position       = pos;
        req.move_first     = move;
        req.cursor_visible = vis;
        return req;
    endfunction

    // mostly the six working modes, a few inits and unused codes;
    // accented letters get picked often enough to hit the remap
    function automatic clcd_pkg::t_item random_request();
        clcd_pkg::t_item req;
        int              pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            req.mode = clcd_pkg::MODE_INIT;
        end else if (pick < 9) begin
            req.mode = MODE_UNUSED;
        end else begin
            req.mode = 3'($urandom_range(clcd_pkg::MODE_CMD, clcd_pkg::MODE_GLYPH));
        end
        if ($urandom_range(99) < 15) begin
            req.byte_value = ACCENTED_CODES[3'($urandom_range(6))];
        end else begin
            req.byte_value = 8'($urandom_range(255));
        end
        req.position       = 5'($urandom_range(31));
        req.move_first     = 1'($urandom_range(1));
        req.cursor_visible = 1'($urandom_range(1));
        return req;
    endfunction

    // one request transfer; valid stays up across back-to-back requests
    task automatic send_request(input clcd_pkg::t_item req);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_item  <= req;
        do @(posedge clk); while (req_stall);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_settings(input logic [7:0] off_cmd, input logic [7:0] on_cmd,
                                    input logic [7:0] glyph_cmd, input logic [15:0] hold);
        write_reg(clcd_pkg::CFG_HIDE_CMD, {8'h00, off_cmd});
        write_reg(clcd_pkg::CFG_SHOW_CMD, {8'h00, on_cmd});
        write_reg(clcd_pkg::CFG_GLYPH_BASE, {8'h00, glyph_cmd});
        write_reg(clcd_pkg::CFG_HOLD_TICKS, hold);
        settings_count++;
    endtask

    // stop offering, wait for every owed strobe, then let the block go
    // quiet; requests that cause no strobes may still be in flight
    task automatic drain_and_settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_strobes != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int gap_pct, input int stall);
        @(posedge clk);
        send_gap_pct = gap_pct;
        stall_pct    = stall;
        repeat (count) send_request(random_request());
    endtask

    task automatic run_directed();
        // display still marked failed: these two must stay silent
        send_request(make_request(clcd_pkg::MODE_CMD, 8'hFF, 5'd31, 1'b1, 1'b1));
        send_request(make_request(clcd_pkg::MODE_CHAR, 8'hE7, 5'd31, 1'b1, 1'b0));
        // wake-up; the unused fields are set to show they are ignored
        send_request(make_request(clcd_pkg::MODE_INIT, 8'hFF, 5'd31, 1'b1, 1'b1));
        send_request(make_request(clcd_pkg::MODE_CMD, 8'h00, 5'd0, 1'b0, 1'b0));
        send_request(make_request(clcd_pkg::MODE_CMD, 8'hFF, 5'd0, 1'b1, 1'b0));
        send_request(make_request(clcd_pkg::MODE_RAW, 8'h00, 5'd31, 1'b0, 1'b1));
        send_request(make_request(clcd_pkg::MODE_RAW, 8'hFF, 5'd0, 1'b1, 1'b0));
        // every accented letter, moving the cursor on every other one
        for (int k = 0; k < 7; k++) begin
            send_request(make_request(clcd_pkg::MODE_CHAR, ACCENTED_CODES[k], 5'(k * 5),
                                      k[0], 1'b0));
        end
        send_request(make_request(clcd_pkg::MODE_CHAR, 8'h00, 5'd15, 1'b0, 1'b1));
        send_request(make_request(clcd_pkg::MODE_CHAR, 8'hFF, 5'd16, 1'b1, 1'b0));
        // line ends on both lines
        send_request(make_request(clcd_pkg::MODE_POS, 8'h00, 5'd0, 1'b0, 1'b0));
        send_request(make_request(clcd_pkg::MODE_POS, 8'hFF, 5'd15, 1'b1, 1'b1));
        send_request(make_request(clcd_pkg::MODE_POS, 8'h00, 5'd16, 1'b0, 1'b0));
        send_request(make_request(clcd_pkg::MODE_POS, 8'hFF, 5'd31, 1'b1, 1'b1));
        send_request(make_request(clcd_pkg::MODE_CURSOR, 8'h00, 5'd0, 1'b0, 1'b1));
        send_request(make_request(clcd_pkg::MODE_CURSOR, 8'hFF, 5'd31, 1'b1, 1'b0));
        send_request(make_request(clcd_pkg::MODE_GLYPH, 8'h5A, 5'd9, 1'b1, 1'b1));
        send_request(make_request(MODE_UNUSED, 8'hA5, 5'd22, 1'b1, 1'b1));
    endtask

    initial begin
        // synchronous reset held, then released on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults first
        run_directed();

        // low extremes for cursor-off, high for the others, shortest hold
        drain_and_settle();
        program_settings(8'h00, 8'hFF, 8'hFF, 16'd1);
        run_random(45, 0, 0);

        // the opposite extremes, with a lazy sender
        drain_and_settle();
        program_settings(8'hFF, 8'h00, 8'h00, 16'hFFFF);
        run_random(45, 63, 0);

        // random settings, receiver stalling most of the time
        drain_and_settle();
        program_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 16'($urandom_range(65535, 1)));
        run_random(45, 0, 63);

        // a write to an index past the list must change nothing
        drain_and_settle();
        program_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 16'($urandom_range(65535, 1)));
        write_reg(3'($urandom_range(7, 4)), 16'($urandom_range(65535)));
        run_random(45, 10, 10);

        // back to defaults; long receiver hold-off while requests keep coming
        drain_and_settle();
        program_settings(clcd_pkg::HIDE_CMD_RESET, clcd_pkg::SHOW_CMD_RESET,
                         clcd_pkg::GLYPH_BASE_RESET, HOLD_TICKS_RESET);
        @(posedge clk);
        hold_armed = 1'b1;
        run_random(30, 0, 0);

        drain_and_settle();
        $display("run covered %0d requests under %0d register settings, all modes",
                 requests_sent, settings_count);
        $display("%0d strobes compared, receiver held off %0d cycles in one stretch",
                 checked_strobes, hold_cycles);
        if (fail_count == 0) begin
            $display("PASS char_lcd_nibble_write_controller");
        end else begin
            $display("FAIL char_lcd_nibble_write_controller");
        end
        $finish;
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d strobes still owed",
                 cycle_count, pending_strobes);
        $display("FAIL char_lcd_nibble_write_controller");
        $finish;
    end

endmodule
